/* rtl/core/software_timer_table_defines.svh */
// ----------------------------------------------------------------------------
// Software timer table assertion macros
// Property wrappers for the checker file of the timer table.
// ----------------------------------------------------------------------------
`ifndef SOFTWARE_TIMER_TABLE_DEFINES_SVH
`define SOFTWARE_TIMER_TABLE_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define STT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define STT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/core/stt_pkg.sv */
// ----------------------------------------------------------------------------
// Software timer table package
// Shared sizes, codes and the command word passed from front to back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package stt_pkg;

   localparam int SLOTS = 32;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [14:0] MAX_INTERVAL_RESET = 15'd2000;

   typedef enum logic [2:0] {
      KIND_ADD     = 3'd0,
      KIND_REMOVE  = 3'd1,
      KIND_QUERY   = 3'd2,
      KIND_CLEANUP = 3'd3,
      KIND_TICK    = 3'd4,
      KIND_CHECK   = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_ADD,
      OP_DEL,
      OP_REMOVE,
      OP_QUERY,
      OP_CLEANUP,
      OP_TICK,
      OP_CHECK
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [15:0] handler;
      logic [31:0] ctx;
      logic [14:0] interval;
      logic        periodic;
   } cmd_type;

endpackage

/* rtl/core/stt_front.sv */
// ----------------------------------------------------------------------------
// Timer table front end
// Accepts requests, holds the interval limit and turns a request into a command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module stt_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [2:0]           req_kind,
   input  logic [15:0]          req_handler_id,
   input  logic [31:0]          req_context_req,
   input  logic signed [15:0]   req_interval,
   input  logic                 req_multi_shot,
   input  logic                 csr_valid,
   input  logic [14:0]          csr_data,
   output logic                 csr_ready,
   input  logic                 q_full,
   output logic                 busy,
   output logic                 push,
   output stt_pkg::cmd_type     push_cmd
);

   logic [14:0] max_interval_ff;
   logic [14:0] max_interval_in;
   logic [14:0] limit;
   logic [14:0] clamped;
   logic        iv_positive;
   logic        h_zero;

   assign csr_ready = 1'b1;
   assign busy      = q_full;
   assign push      = start && !q_full;

   assign max_interval_in = (csr_valid && csr_ready) ? csr_data : max_interval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_interval_ff <= stt_pkg::MAX_INTERVAL_RESET;
      end else begin
         max_interval_ff <= max_interval_in;
      end
   end

   // A limit of zero behaves as one.
   assign limit       = (max_interval_ff == 15'd0) ? 15'd1 : max_interval_ff;
   assign iv_positive = !req_interval[15] && (req_interval != 16'sd0);
   assign h_zero      = (req_handler_id == 16'd0);

   always_comb begin
      clamped = (req_interval[14:0] > limit) ? limit : req_interval[14:0];
      if (clamped == 15'd1 && !req_multi_shot) begin
         clamped = 15'd2;
      end
   end

   always_comb begin
      push_cmd.handler  = req_handler_id;
      push_cmd.ctx      = req_context_req;
      push_cmd.interval = clamped;
      push_cmd.periodic = req_multi_shot;
      priority if (req_kind == stt_pkg::KIND_ADD) begin
         push_cmd.op = h_zero ? stt_pkg::OP_NOP :
                       (iv_positive ? stt_pkg::OP_ADD : stt_pkg::OP_DEL);
      end else if (req_kind == stt_pkg::KIND_REMOVE) begin
         push_cmd.op = h_zero ? stt_pkg::OP_NOP : stt_pkg::OP_REMOVE;
      end else if (req_kind == stt_pkg::KIND_QUERY) begin
         push_cmd.op = h_zero ? stt_pkg::OP_NOP : stt_pkg::OP_QUERY;
      end else if (req_kind == stt_pkg::KIND_CLEANUP) begin
         push_cmd.op = stt_pkg::OP_CLEANUP;
      end else if (req_kind == stt_pkg::KIND_TICK) begin
         push_cmd.op = stt_pkg::OP_TICK;
      end else if (req_kind == stt_pkg::KIND_CHECK) begin
         push_cmd.op = stt_pkg::OP_CHECK;
      end else begin
         push_cmd.op = stt_pkg::OP_NOP;
      end
   end

endmodule

/* rtl/core/stt_queue.sv */
// ----------------------------------------------------------------------------
// Timer table command queue
// Short first-in first-out buffer between the front end and the slot engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module stt_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  stt_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output stt_pkg::cmd_type head
);

   stt_pkg::cmd_type                  entry_ff [stt_pkg::QUEUE_DEPTH];
   logic [stt_pkg::QPTR_W-1:0]        wr_ptr_ff;
   logic [stt_pkg::QPTR_W-1:0]        wr_ptr_in;
   logic [stt_pkg::QPTR_W-1:0]        rd_ptr_ff;
   logic [stt_pkg::QPTR_W-1:0]        rd_ptr_in;
   logic [stt_pkg::QCNT_W-1:0]        count_ff;
   logic [stt_pkg::QCNT_W-1:0]        count_in;

   assign full  = (count_ff == stt_pkg::QCNT_W'(stt_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == stt_pkg::QPTR_W'(stt_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == stt_pkg::QPTR_W'(stt_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/core/stt_back.sv */
// ----------------------------------------------------------------------------
// Timer table slot engine
// Holds the slot table and runs each command as a scan over all slots.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module stt_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  stt_pkg::cmd_type q_head,
   output logic             q_pop,
   output logic             rsp_strobe,
   output logic             rsp_ok,
   output logic [14:0]      rsp_ticks_left,
   output logic             rsp_fired,
   output logic [15:0]      rsp_fired_handler,
   output logic [31:0]      rsp_fired_context,
   output logic             rsp_last
);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_type;

   state_type                   state_ff;
   stt_pkg::cmd_type            cmd_ff;
   logic [stt_pkg::IDX_W-1:0]   idx_ff;
   logic                        found_ff;
   logic [stt_pkg::IDX_W-1:0]   found_idx_ff;
   logic                        free_found_ff;
   logic [stt_pkg::IDX_W-1:0]   free_idx_ff;
   logic [14:0]                 left_ff;
   logic                        pend_ff;
   logic [15:0]                 pend_handler_ff;
   logic [31:0]                 pend_ctx_ff;

   logic [15:0]                 handler_ff  [stt_pkg::SLOTS];
   logic [31:0]                 ctx_ff      [stt_pkg::SLOTS];
   logic [14:0]                 period_ff   [stt_pkg::SLOTS];
   logic [14:0]                 rem_ff      [stt_pkg::SLOTS];
   logic                        periodic_ff [stt_pkg::SLOTS];

   logic [15:0]                 h_rd;
   logic [31:0]                 ctx_rd;
   logic [14:0]                 period_rd;
   logic [14:0]                 rem_rd;
   logic                        periodic_rd;
   logic                        is_match;
   logic                        expired;

   logic                        wr_en;
   logic [stt_pkg::IDX_W-1:0]   wr_idx;
   logic [15:0]                 wr_handler;
   logic [31:0]                 wr_ctx;
   logic [14:0]                 wr_period;
   logic [14:0]                 wr_rem;
   logic                        wr_periodic;

   assign h_rd        = handler_ff[idx_ff];
   assign ctx_rd      = ctx_ff[idx_ff];
   assign period_rd   = period_ff[idx_ff];
   assign rem_rd      = rem_ff[idx_ff];
   assign periodic_rd = periodic_ff[idx_ff];
   assign is_match    = (h_rd == cmd_ff.handler) && (ctx_rd == cmd_ff.ctx);
   assign expired     = (h_rd != 16'd0) && (rem_rd == 15'd0);
   assign q_pop       = (state_ff == S_IDLE) && !q_empty;

   // One slot write per cycle: the scanned slot, or the add target at the end.
   always_comb begin
      wr_en       = 1'b0;
      wr_idx      = idx_ff;
      wr_handler  = h_rd;
      wr_ctx      = ctx_rd;
      wr_period   = period_rd;
      wr_rem      = rem_rd;
      wr_periodic = periodic_rd;
      if (state_ff == S_SCAN) begin
         unique case (cmd_ff.op)
            stt_pkg::OP_DEL, stt_pkg::OP_REMOVE: begin
               if (is_match && !found_ff) begin
                  wr_en      = 1'b1;
                  wr_handler = 16'd0;
                  wr_ctx     = 32'd0;
               end
            end
            stt_pkg::OP_CLEANUP: begin
               if (ctx_rd == cmd_ff.ctx) begin
                  wr_en      = 1'b1;
                  wr_handler = 16'd0;
                  wr_ctx     = 32'd0;
               end
            end
            stt_pkg::OP_TICK: begin
               if (h_rd != 16'd0 && rem_rd != 15'd0) begin
                  wr_en  = 1'b1;
                  wr_rem = rem_rd - 15'd1;
               end
            end
            stt_pkg::OP_CHECK: begin
               if (expired) begin
                  wr_en = 1'b1;
                  if (periodic_rd) begin
                     wr_rem = period_rd;
                  end else begin
                     wr_handler = 16'd0;
                     wr_ctx     = 32'd0;
                  end
               end
            end
            default: begin
            end
         endcase
      end else if (state_ff == S_FINISH && cmd_ff.op == stt_pkg::OP_ADD &&
                   (found_ff || free_found_ff)) begin
         wr_en       = 1'b1;
         wr_idx      = found_ff ? found_idx_ff : free_idx_ff;
         wr_handler  = cmd_ff.handler;
         wr_ctx      = cmd_ff.ctx;
         wr_period   = cmd_ff.interval;
         wr_rem      = cmd_ff.interval;
         wr_periodic = cmd_ff.periodic;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < stt_pkg::SLOTS; i++) begin
            handler_ff[i]  <= 16'd0;
            ctx_ff[i]      <= 32'd0;
            period_ff[i]   <= 15'd0;
            rem_ff[i]      <= 15'd0;
            periodic_ff[i] <= 1'b0;
         end
      end else if (wr_en) begin
         handler_ff[wr_idx]  <= wr_handler;
         ctx_ff[wr_idx]      <= wr_ctx;
         period_ff[wr_idx]   <= wr_period;
         rem_ff[wr_idx]      <= wr_rem;
         periodic_ff[wr_idx] <= wr_periodic;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rsp_strobe <= 1'b0;
         pend_ff    <= 1'b0;
      end else begin
         rsp_strobe <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (!q_empty) begin
                  cmd_ff        <= q_head;
                  idx_ff        <= '0;
                  found_ff      <= 1'b0;
                  free_found_ff <= 1'b0;
                  pend_ff       <= 1'b0;
                  left_ff       <= 15'd0;
                  state_ff      <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (is_match && !found_ff) begin
                  found_ff     <= 1'b1;
                  found_idx_ff <= idx_ff;
                  left_ff      <= rem_rd;
               end
               if (h_rd == 16'd0 && !free_found_ff) begin
                  free_found_ff <= 1'b1;
                  free_idx_ff   <= idx_ff;
               end
               // An expiry is held back until the next one is found, so the final one can carry last.
               if (cmd_ff.op == stt_pkg::OP_CHECK && expired) begin
                  if (pend_ff) begin
                     rsp_strobe        <= 1'b1;
                     rsp_ok            <= 1'b0;
                     rsp_ticks_left    <= 15'd0;
                     rsp_fired         <= 1'b1;
                     rsp_fired_handler <= pend_handler_ff;
                     rsp_fired_context <= pend_ctx_ff;
                     rsp_last          <= 1'b0;
                  end
                  pend_ff         <= 1'b1;
                  pend_handler_ff <= h_rd;
                  pend_ctx_ff     <= ctx_rd;
               end
               if (idx_ff == stt_pkg::LAST_IDX) begin
                  state_ff <= S_FINISH;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_FINISH: begin
               rsp_strobe        <= 1'b1;
               rsp_ok            <= (cmd_ff.op == stt_pkg::OP_ADD) &&
                                    (found_ff || free_found_ff);
               rsp_ticks_left    <= ((cmd_ff.op == stt_pkg::OP_REMOVE ||
                                      cmd_ff.op == stt_pkg::OP_QUERY) && found_ff) ?
                                    left_ff : 15'd0;
               rsp_fired         <= (cmd_ff.op == stt_pkg::OP_CHECK) && pend_ff;
               rsp_fired_handler <= ((cmd_ff.op == stt_pkg::OP_CHECK) && pend_ff) ?
                                    pend_handler_ff : 16'd0;
               rsp_fired_context <= ((cmd_ff.op == stt_pkg::OP_CHECK) && pend_ff) ?
                                    pend_ctx_ff : 32'd0;
               rsp_last          <= 1'b1;
               state_ff          <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

/* rtl/core/software_timer_table.sv */
// ----------------------------------------------------------------------------
// Software timer table
// Slot table of one-shot and periodic timers keyed by handler and context.
// ----------------------------------------------------------------------------
//
// Channel     Handshake                 Payload
// request     start / busy              req_kind, req_handler_id, req_context_req,
//                                       req_interval, req_multi_shot
// result      rsp_strobe (one cycle)    rsp_ok, rsp_ticks_left, rsp_fired,
//                                       rsp_fired_handler, rsp_fired_context, rsp_last
// register    csr_valid / csr_ready     csr_data (max_interval)
//
// Every request scans all slots, one slot per clock. The slot engine takes a
// request from the queue while idle, scans every slot in turn, then registers
// the final result in its finish state. A check request may strobe results
// during the scan as well, in back-to-back cycles when neighboring slots
// expire together.
// Reset clears every slot at once and sets max_interval to 2000.
// The request queue holds two requests; busy is high while it is full. The
// result side cannot stall, so the scan never waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module software_timer_table (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_kind,
   input  logic [15:0]        req_handler_id,
   input  logic [31:0]        req_context_req,
   input  logic signed [15:0] req_interval,
   input  logic               req_multi_shot,
   output logic               rsp_strobe,
   output logic               rsp_ok,
   output logic [14:0]        rsp_ticks_left,
   output logic               rsp_fired,
   output logic [15:0]        rsp_fired_handler,
   output logic [31:0]        rsp_fired_context,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [14:0]        csr_data
);

   // Front end to queue.
   logic             push;
   stt_pkg::cmd_type push_cmd;
   logic             q_full;

   // Queue to slot engine.
   logic             q_pop;
   logic             q_empty;
   stt_pkg::cmd_type q_head;

   // The front end decodes the request and applies the interval limit at
   // acceptance; the user must change the limit only while idle (not enforced).
   stt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_kind        (req_kind),
      .req_handler_id  (req_handler_id),
      .req_context_req (req_context_req),
      .req_interval    (req_interval),
      .req_multi_shot  (req_multi_shot),
      .csr_valid       (csr_valid),
      .csr_data        (csr_data),
      .csr_ready       (csr_ready),
      .q_full          (q_full),
      .busy            (busy),
      .push            (push),
      .push_cmd        (push_cmd)
   );

   stt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   // The slot engine owns the table and drives the result registers.
   stt_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .rsp_strobe        (rsp_strobe),
      .rsp_ok            (rsp_ok),
      .rsp_ticks_left    (rsp_ticks_left),
      .rsp_fired         (rsp_fired),
      .rsp_fired_handler (rsp_fired_handler),
      .rsp_fired_context (rsp_fired_context),
      .rsp_last          (rsp_last)
   );

endmodule

/* rtl/core/stt_checker.sv */
// ----------------------------------------------------------------------------
// Software timer table checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "software_timer_table_defines.svh"
module stt_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_strobe,
   input logic               rsp_ok,
   input logic               rsp_fired,
   input logic [15:0]        rsp_fired_handler,
   input logic               rsp_last
);

   // A successful add never reports an expiry.
   `STT_ASSERT(a_ok_not_fired, rsp_strobe && rsp_ok |-> !rsp_fired, "ok with fired")

   // Only expiry reports can be followed by more results of the same request.
   `STT_ASSERT(a_plain_is_last, rsp_strobe && !rsp_fired |-> rsp_last, "single result not last")

   // Expired timers always belong to a real handler.
   `STT_ASSERT(a_fired_handler, rsp_strobe && rsp_fired |-> rsp_fired_handler != 16'd0, "fired without handler")

   // No result leaves the block in the cycle after reset.
   `STT_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_strobe, "result after reset")

endmodule

bind software_timer_table stt_checker u_stt_checker (.*);
